### src/clipped_alpha_blit_unit_defines.svh
// Assertion macros for the clipped alpha blit unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef CLIPPED_ALPHA_BLIT_UNIT_DEFINES_SVH
`define CLIPPED_ALPHA_BLIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cab_pkg.sv
// Shared types, codes and blend functions for the clipped alpha blit unit.
// No dependencies.
package cab_pkg;

    localparam int PIX_W      = 32;
    localparam int ADDR_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_W      = 12;
    localparam int CNT_W      = 11;
    localparam int BOX_X_W    = 10;
    localparam int BOX_Y_W    = 10;
    localparam int BOX_W_W    = 11;
    localparam int BOX_H_W    = 10;

    localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]       ALPHA_CLEAR  = 8'd0;

    // Blend mode codes; the unused code behaves as copy.
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_ALPHA = 2'd1;
    localparam logic [1:0] MODE_COVER = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE   = 3'd0,
        CFG_FILL_COLOR   = 3'd1,
        CFG_DEST_X       = 3'd2,
        CFG_DEST_Y       = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                write_enable;
        logic [ADDR_W-1:0]   address;
        logic [PIX_W-1:0]    new_pixel;
        logic                image_done;
        logic                box_valid;
        logic [BOX_X_W-1:0]  box_x;
        logic [BOX_Y_W-1:0]  box_y;
        logic [BOX_W_W-1:0]  box_w;
        logic [BOX_H_W-1:0]  box_h;
    } t_result;

    // d + floor((s - d) * a / 256) on unsigned bytes, one multiply.
    function automatic logic [7:0] mix_byte(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
        logic [7:0]  diff;
        logic [15:0] prod;
        logic [15:0] up;
        if (s >= d) begin
            diff = s - d;
        end else begin
            diff = d - s;
        end
        prod = 16'(diff) * 16'(a);
        up   = prod + 16'd255;
        if (s >= d) begin
            return d + prod[15:8];
        end else begin
            return d - up[15:8];
        end
    endfunction

    // Blend three colour bytes, keep the destination top byte.
    function automatic logic [PIX_W-1:0] mix_rgb(input logic [PIX_W-1:0] dst,
                                                 input logic [23:0] rgb,
                                                 input logic [7:0] a);
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        b = mix_byte(dst[7:0],   rgb[7:0],   a);
        g = mix_byte(dst[15:8],  rgb[15:8],  a);
        r = mix_byte(dst[23:16], rgb[23:16], a);
        return {dst[31:24], r, g, b};
    endfunction

endpackage

### src/cab_if.sv
// Handshake channels of the clipped alpha blit unit: pixel/flush in, result out,
// configuration writes. Depends on cab_pkg.
interface cab_pix_if import cab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;

    modport source (output valid, output req_type, output src_pixel, output dst_pixel,
                    input ready);
    modport sink   (input valid, input req_type, input src_pixel, input dst_pixel,
                    output ready);
endinterface

interface cab_res_if import cab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  address;
    logic [PIX_W-1:0]   new_pixel;
    logic               image_done;
    logic               box_valid;
    logic [BOX_X_W-1:0] box_x;
    logic [BOX_Y_W-1:0] box_y;
    logic [BOX_W_W-1:0] box_w;
    logic [BOX_H_W-1:0] box_h;

    modport source (output valid, output write_enable, output address, output new_pixel,
                    output image_done, output box_valid, output box_x, output box_y,
                    output box_w, output box_h, input ready);
    modport sink   (input valid, input write_enable, input address, input new_pixel,
                    input image_done, input box_valid, input box_x, input box_y,
                    input box_w, input box_h, output ready);
endinterface

interface cab_cfg_if import cab_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/clipped_alpha_blit_unit.sv
// Clipped alpha blit unit: position tracking, clipping, blending, dirty box.
// Depends on cab_pkg, cab_if.sv and clipped_alpha_blit_unit_defines.svh.
//
// Takes one item per clock: a source pixel (with the screen pixel under it) or a
// flush request. Pixels arrive in raster order over an image of image_width x
// image_height placed at (dest_x, dest_y); each yields one result with a write
// address and composited pixel, or write_enable low when the pixel falls off the
// SCREEN_W x SCREEN_H screen. image_done marks the last pixel of the image. A
// flush reports the bounding box of everything written since the last flush and
// empties it. Throughput is one item per cycle. Stage one walks the column/row
// counters and clips; stage two blends (three 8x8 byte multiplies), forms the
// address (one constant multiply), grows the dirty box and loads the result
// register. Only o_res.ready stalls the pipe. Any configuration write
// to a known register restarts the image at column 0, row 0; configure only
// while no items are in flight.
`include "clipped_alpha_blit_unit_defines.svh"

module clipped_alpha_blit_unit import cab_pkg::*; #(
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 768
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cab_pix_if.sink   i_pix,
    cab_res_if.source o_res,
    cab_cfg_if.sink   i_cfg
);

    localparam int XW  = $clog2(SCREEN_W);
    localparam int YW  = $clog2(SCREEN_H);
    localparam int XW1 = $clog2(SCREEN_W + 1);
    localparam int YW1 = $clog2(SCREEN_H + 1);
    localparam logic [12:0] SCR_W13 = 13'(SCREEN_W);
    localparam logic [12:0] SCR_H13 = 13'(SCREEN_H);

    typedef struct packed {
        logic             flush;
        logic             on_screen;
        logic             done;
        logic [XW-1:0]    ux;
        logic [YW-1:0]    uy;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
    } t_stage1;

    // configuration registers
    logic [1:0]            r_mode;
    logic [23:0]           r_fill;
    logic [DIM_W-1:0]      r_dest_x;
    logic [DIM_W-1:0]      r_dest_y;
    logic [DIM_W-1:0]      r_img_w;
    logic [DIM_W-1:0]      r_img_h;

    // image position
    logic [CNT_W-1:0]      r_col;
    logic [CNT_W-1:0]      r_row;

    // dirty box, right/bottom exclusive
    logic                  r_box_empty;
    logic [XW-1:0]         r_box_left;
    logic [YW-1:0]         r_box_top;
    logic [XW1-1:0]        r_box_right;
    logic [YW1-1:0]        r_box_bottom;

    // pipeline
    logic                  r_s1_valid;
    t_stage1               r_s1;
    t_stage1               n_s1;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic                  adv_out;
    logic                  s1_ready;
    logic                  pix_acc;
    logic                  cfg_acc;
    logic                  cfg_hit;

    // stage one signals
    logic [DIM_W-1:0]      w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic                  dim_zero;
    logic [CNT_W-1:0]      col_eff;
    logic [CNT_W-1:0]      row_eff;
    logic [DIM_W-1:0]      col_inc;
    logic [DIM_W-1:0]      row_inc;
    logic                  col_wrap;
    logic                  row_wrap;
    logic signed [13:0]    sx;
    logic signed [13:0]    sy;
    logic                  on_x;
    logic                  on_y;
    logic [CNT_W-1:0]      n_col;
    logic [CNT_W-1:0]      n_row;

    // stage two signals
    logic [23:0]           mix_color;
    logic [7:0]            mix_alpha;
    logic [PIX_W-1:0]      pix_mix;
    logic [PIX_W-1:0]      pix_new;
    logic [31:0]           addr_full;
    logic [XW1-1:0]        ux_end;
    logic [YW1-1:0]        uy_end;

    assign adv_out  = !r_out_valid || o_res.ready;
    assign s1_ready = !r_s1_valid || adv_out;
    assign pix_acc  = i_pix.valid && s1_ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign cfg_hit  = cfg_acc && (i_cfg.index <= CFG_IMAGE_HEIGHT);

    assign i_pix.ready = s1_ready;
    assign i_cfg.ready = 1'b1;

    //------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_COPY;
            r_fill   <= '0;
            r_dest_x <= '0;
            r_dest_y <= '0;
            r_img_w  <= '0;
            r_img_h  <= '0;
        end else if (cfg_acc) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BLEND_MODE:   r_mode   <= i_cfg.data[1:0];
                CFG_FILL_COLOR:   r_fill   <= i_cfg.data;
                CFG_DEST_X:       r_dest_x <= i_cfg.data[DIM_W-1:0];
                CFG_DEST_Y:       r_dest_y <= i_cfg.data[DIM_W-1:0];
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg.data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Stage one: position walk and clipping
    //------------------------------------------------------------------
    always_comb begin
        w_eff    = (r_img_w > MAX_DIM) ? MAX_DIM : r_img_w;
        h_eff    = (r_img_h > MAX_DIM) ? MAX_DIM : r_img_h;
        dim_zero = (w_eff == '0) || (h_eff == '0);

        // counters left over from a larger image wrap to zero
        col_eff = (DIM_W'(r_col) >= w_eff) ? '0 : r_col;
        row_eff = (DIM_W'(r_row) >= h_eff) ? '0 : r_row;
        col_inc = DIM_W'(col_eff) + DIM_W'(1);
        row_inc = DIM_W'(row_eff) + DIM_W'(1);
        col_wrap = (col_inc >= w_eff);
        row_wrap = (row_inc >= h_eff);

        sx   = 14'($signed(r_dest_x)) + $signed({3'b000, col_eff});
        sy   = 14'($signed(r_dest_y)) + $signed({3'b000, row_eff});
        on_x = !sx[13] && (sx[12:0] < SCR_W13);
        on_y = !sy[13] && (sy[12:0] < SCR_H13);

        n_s1.flush     = (i_pix.req_type == REQ_FLUSH);
        n_s1.on_screen = !dim_zero && on_x && on_y;
        n_s1.done      = dim_zero || (col_wrap && row_wrap);
        n_s1.ux        = sx[XW-1:0];
        n_s1.uy        = sy[YW-1:0];
        n_s1.src       = i_pix.src_pixel;
        n_s1.dst       = i_pix.dst_pixel;

        if (dim_zero) begin
            n_col = '0;
            n_row = '0;
        end else if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_inc[CNT_W-1:0];
        end else begin
            n_col = col_inc[CNT_W-1:0];
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc && i_pix.req_type == REQ_PIXEL) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv_out) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1 <= n_s1;
        end
    end

    //------------------------------------------------------------------
    // Stage two: blend, address, dirty box
    //------------------------------------------------------------------
    always_comb begin
        // one shared blender: coverage mixes the fill color by the low byte,
        // per-pixel alpha mixes the source color by the top byte
        mix_color = (r_mode == MODE_COVER) ? r_fill : r_s1.src[23:0];
        mix_alpha = (r_mode == MODE_COVER) ? r_s1.src[7:0] : r_s1.src[31:24];
        pix_mix   = mix_rgb(r_s1.dst, mix_color, mix_alpha);

        case (r_mode)
            MODE_ALPHA: begin
                if (r_s1.src[31:24] == ALPHA_CLEAR) begin
                    pix_new = r_s1.dst;
                end else if (r_s1.src[31:24] == ALPHA_OPAQUE) begin
                    pix_new = {r_s1.dst[31:24], r_s1.src[23:0]};
                end else begin
                    pix_new = pix_mix;
                end
            end
            MODE_COVER: pix_new = pix_mix;
            default:    pix_new = r_s1.src;
        endcase

        addr_full = 32'(r_s1.uy) * 32'(SCREEN_W) + 32'(r_s1.ux);
        ux_end    = XW1'(r_s1.ux) + XW1'(1);
        uy_end    = YW1'(r_s1.uy) + YW1'(1);

        n_out = '0;
        if (r_s1.flush) begin
            if (!r_box_empty) begin
                n_out.box_valid = 1'b1;
                n_out.box_x     = BOX_X_W'(r_box_left);
                n_out.box_y     = BOX_Y_W'(r_box_top);
                n_out.box_w     = BOX_W_W'(r_box_right - XW1'(r_box_left));
                n_out.box_h     = BOX_H_W'(r_box_bottom - YW1'(r_box_top));
            end
        end else begin
            n_out.image_done = r_s1.done;
            if (r_s1.on_screen) begin
                n_out.write_enable = 1'b1;
                n_out.address      = addr_full[ADDR_W-1:0];
                n_out.new_pixel    = pix_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_empty  <= 1'b1;
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_right  <= '0;
            r_box_bottom <= '0;
        end else if (adv_out && r_s1_valid) begin
            if (r_s1.flush) begin
                r_box_empty  <= 1'b1;
                r_box_left   <= '0;
                r_box_top    <= '0;
                r_box_right  <= '0;
                r_box_bottom <= '0;
            end else if (r_s1.on_screen) begin
                r_box_empty <= 1'b0;
                if (r_box_empty || r_s1.ux < r_box_left) begin
                    r_box_left <= r_s1.ux;
                end
                if (r_box_empty || r_s1.uy < r_box_top) begin
                    r_box_top <= r_s1.uy;
                end
                if (r_box_empty || ux_end > r_box_right) begin
                    r_box_right <= ux_end;
                end
                if (r_box_empty || uy_end > r_box_bottom) begin
                    r_box_bottom <= uy_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.write_enable = r_out.write_enable;
    assign o_res.address      = r_out.address;
    assign o_res.new_pixel    = r_out.new_pixel;
    assign o_res.image_done   = r_out.image_done;
    assign o_res.box_valid    = r_out.box_valid;
    assign o_res.box_x        = r_out.box_x;
    assign o_res.box_y        = r_out.box_y;
    assign o_res.box_w        = r_out.box_w;
    assign o_res.box_h        = r_out.box_h;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    // a flush result that carries a box never carries a pixel write or an image end
    `CAB_ASSERT_NOW(a_flush_no_write, r_out_valid && r_out.box_valid, !r_out.write_enable && !r_out.image_done, "flush result carries a write")
    // an on-screen pixel in stage one lies inside the screen
    `CAB_ASSERT_NOW(a_ux_in_screen, r_s1_valid && !r_s1.flush && r_s1.on_screen, (32'(r_s1.ux) < 32'(SCREEN_W)) && (32'(r_s1.uy) < 32'(SCREEN_H)), "clipped position off screen")
    // a write to a known register restarts the image position
    `CAB_ASSERT_NEXT(a_cfg_restart, cfg_hit, r_col == '0 && r_row == '0, "position not restarted")

endmodule

### sim/tb.sv
// Testbench for clipped_alpha_blit_unit: directed and random pixel/flush items
// checked against a behavioral predictor. Depends on cab_pkg and the cab_*_if interfaces.
module tb;
    import cab_pkg::*;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 768;
    localparam int QUIET_CYCLES = 4;       // pipeline is two deep; a little margin
    localparam int RUN_LIMIT = 3000000;    // time units, far past the slowest legal run

    // Register indexes outside the list; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;
    // Unused blend code, acts as copy.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic             req;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
    } t_pix_item;

    logic i_clk;
    logic i_rst_n;

    cab_pix_if pix ();
    cab_res_if res ();
    cab_cfg_if cfg ();

    clipped_alpha_blit_unit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: register copies, raster position, dirty box.
    logic [1:0]       m_mode;
    logic [23:0]      m_fill;
    logic [DIM_W-1:0] m_dx, m_dy, m_w, m_h;
    int unsigned      col_pos, row_pos;
    bit               box_none;
    int unsigned      box_l, box_t, box_r, box_b;

    t_pix_item pix_backlog[$];     // items waiting for the driver
    t_result   due_results[$];     // predicted results, oldest first
    int        send_idle_pct;
    int        recv_stall_pct;
    int        err_count;
    int        sent_count;

    // One unsigned byte moved toward s by a/256, with the signed step rounded down.
    function automatic logic [7:0] blend_chan(int d, int s, int a);
        if (s >= d) begin
            return 8'(d + (((s - d) * a) >> 8));
        end
        return 8'(d - ((((d - s) * a) + 255) >> 8));
    endfunction

    function automatic logic [PIX_W-1:0] blend_rgb(logic [PIX_W-1:0] dst, logic [23:0] rgb,
                                                   logic [7:0] a);
        logic [PIX_W-1:0] mixed;
        int k;
        mixed = dst;    // top byte stays
        for (k = 0; k < 3; k++) begin
            mixed[8*k +: 8] = blend_chan(int'(dst[8*k +: 8]), int'(rgb[8*k +: 8]), int'(a));
        end
        return mixed;
    endfunction

    function automatic logic [PIX_W-1:0] shade_pixel(logic [PIX_W-1:0] src,
                                                     logic [PIX_W-1:0] dst);
        case (m_mode)
            MODE_ALPHA: begin
                if (src[31:24] == ALPHA_CLEAR) begin
                    return dst;
                end
                if (src[31:24] == ALPHA_OPAQUE) begin
                    return {dst[31:24], src[23:0]};
                end
                return blend_rgb(dst, src[23:0], src[31:24]);
            end
            MODE_COVER: return blend_rgb(dst, m_fill, src[7:0]);
            default:    return src;
        endcase
    endfunction

    // Advance the predictor by one accepted item and return its result.
    function automatic t_result blit_step(t_pix_item it);
        t_result r;
        int unsigned wd, ht;
        int sx, sy;
        r  = '0;
        wd = (m_w > MAX_DIM) ? MAX_DIM : m_w;
        ht = (m_h > MAX_DIM) ? MAX_DIM : m_h;

        if (it.req == REQ_FLUSH) begin
            if (!box_none) begin
                r.box_valid = 1'b1;
                r.box_x     = BOX_X_W'(box_l);
                r.box_y     = BOX_Y_W'(box_t);
                r.box_w     = BOX_W_W'(box_r - box_l);
                r.box_h     = BOX_H_W'(box_b - box_t);
            end
            box_none = 1'b1;
            box_l = 0; box_t = 0; box_r = 0; box_b = 0;
            return r;
        end

        // Empty image: nothing drawn, every pixel ends it.
        if (wd == 0 || ht == 0) begin
            col_pos = 0;
            row_pos = 0;
            r.image_done = 1'b1;
            return r;
        end
        if (col_pos >= wd) col_pos = 0;
        if (row_pos >= ht) row_pos = 0;

        sx = int'($signed(m_dx)) + int'(col_pos);
        sy = int'($signed(m_dy)) + int'(row_pos);
        if (sx >= 0 && sy >= 0 && sx < SCREEN_W && sy < SCREEN_H) begin
            r.write_enable = 1'b1;
            r.address      = ADDR_W'(sy * SCREEN_W + sx);
            r.new_pixel    = shade_pixel(it.src, it.dst);
            if (box_none) begin
                box_none = 1'b0;
                box_l = sx; box_t = sy; box_r = sx + 1; box_b = sy + 1;
            end else begin
                if (sx < int'(box_l))      box_l = sx;
                if (sy < int'(box_t))      box_t = sy;
                if (sx + 1 > int'(box_r))  box_r = sx + 1;
                if (sy + 1 > int'(box_b))  box_b = sy + 1;
            end
        end

        // Raster walk; last pixel of the last row flags image_done.
        if (col_pos + 1 >= wd) begin
            col_pos = 0;
            if (row_pos + 1 >= ht) begin
                row_pos = 0;
                r.image_done = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    // Driver: predict on acceptance, then load the next item or idle.
    always @(posedge i_clk) begin
        t_pix_item nxt;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                due_results.push_back(blit_step('{pix.req_type, pix.src_pixel, pix.dst_pixel}));
            end
            if (!pix.valid || pix.ready) begin
                if (pix_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pix_backlog.pop_front();
                    pix.valid     <= 1'b1;
                    pix.req_type  <= nxt.req;
                    pix.src_pixel <= nxt.src;
                    pix.dst_pixel <= nxt.dst;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                got = '{res.write_enable, res.address, res.new_pixel, res.image_done,
                        res.box_valid, res.box_x, res.box_y, res.box_w, res.box_h};
                if (due_results.size() == 0) begin
                    if (err_count < 10) begin
                        $display("unexpected result: we=%0b addr=%05h pix=%08h done=%0b",
                                 got.write_enable, got.address, got.new_pixel,
                                 got.image_done);
                    end
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        if (err_count < 10) begin
                            $display("mismatch: exp we=%0b addr=%05h pix=%08h done=%0b box=%0b %0d %0d %0d %0d",
                                     want.write_enable, want.address, want.new_pixel,
                                     want.image_done, want.box_valid, want.box_x,
                                     want.box_y, want.box_w, want.box_h);
                            $display("          got we=%0b addr=%05h pix=%08h done=%0b box=%0b %0d %0d %0d %0d",
                                     got.write_enable, got.address, got.new_pixel,
                                     got.image_done, got.box_valid, got.box_x,
                                     got.box_y, got.box_w, got.box_h);
                        end
                        err_count++;
                    end
                end
            end
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Block until nothing is queued, in flight or owed, then let the pipe settle.
    // Sampled on the falling edge so the driver's updates of this cycle are seen.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pix_backlog.size() != 0 || pix.valid || due_results.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only issued with the block idle.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_BLEND_MODE:   m_mode = data[1:0];
            CFG_FILL_COLOR:   m_fill = data[23:0];
            CFG_DEST_X:       m_dx   = data[DIM_W-1:0];
            CFG_DEST_Y:       m_dy   = data[DIM_W-1:0];
            CFG_IMAGE_WIDTH:  m_w    = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: m_h    = data[DIM_W-1:0];
            default:          return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // Full image setup; unused upper data bits get random junk.
    task automatic set_image(logic [1:0] mode, logic [23:0] fill, int dx, int dy,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        cfg_write(CFG_BLEND_MODE,   {22'($urandom), mode});
        cfg_write(CFG_FILL_COLOR,   fill);
        cfg_write(CFG_DEST_X,       {12'($urandom), 12'(dx)});
        cfg_write(CFG_DEST_Y,       {12'($urandom), 12'(dy)});
        cfg_write(CFG_IMAGE_WIDTH,  {12'($urandom), w});
        cfg_write(CFG_IMAGE_HEIGHT, {12'($urandom), h});
    endtask

    task automatic push_pix(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
        pix_backlog.push_back('{REQ_PIXEL, src, dst});
        sent_count++;
    endtask

    task automatic push_flush();
        pix_backlog.push_back('{REQ_FLUSH, PIX_W'($urandom), PIX_W'($urandom)});
        sent_count++;
    endtask

    // Source word biased so alpha/coverage bytes hit clear and opaque often.
    function automatic logic [PIX_W-1:0] rand_src();
        logic [PIX_W-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: begin v[31:24] = ALPHA_CLEAR;  v[7:0] = ALPHA_CLEAR;  end
            1: begin v[31:24] = ALPHA_OPAQUE; v[7:0] = ALPHA_OPAQUE; end
            default: ;
        endcase
        return v;
    endfunction

    // Placement often near screen edges or at the field extremes so clipping is exercised.
    function automatic int rand_coord(int span);
        case ($urandom_range(4))
            0:       return int'($urandom_range(16)) - 8;
            1:       return span - 4 + int'($urandom_range(8));
            2:       return int'($urandom_range(4095)) - 2048;
            3:       return int'($urandom_range(span - 1));
            default: return ($urandom_range(1) != 0) ? 2047 : -2048;
        endcase
    endfunction

    task automatic random_image();
        logic [DIM_W-1:0] w, h;
        int n, k;
        case ($urandom_range(19))
            0: begin w = 0; h = DIM_W'($urandom_range(4)); end
            1: begin w = DIM_W'($urandom_range(4)); h = 0; end
            2: begin
                w = ($urandom_range(1) != 0) ? 12'hFFF : DIM_W'($urandom_range(1000, 2048));
                h = DIM_W'($urandom_range(1, 2));
            end
            3: begin w = 1; h = ($urandom_range(1) != 0) ? 12'hFFF : 12'd2048; end
            default: begin
                w = DIM_W'($urandom_range(1, 6));
                h = DIM_W'($urandom_range(1, 6));
            end
        endcase
        set_image(2'($urandom), 24'($urandom), rand_coord(SCREEN_W), rand_coord(SCREEN_H),
                  w, h);
        // Whole image most of the time, sometimes a wrap past the end or a cut.
        n = int'(w) * int'(h);
        if (n == 0)             n = $urandom_range(1, 3);
        else if (n > 36)        n = $urandom_range(1, 12);
        else if ($urandom_range(4) == 0) n = n + int'($urandom_range(1, 5));
        else if ($urandom_range(4) == 0) n = $urandom_range(1, n);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0) push_flush();
            push_pix(rand_src(), $urandom);
        end
        if ($urandom_range(1) != 0) push_flush();
    endtask

    initial begin
        int ph, goal;
        // Known values on every input before the first edge.
        i_rst_n        = 1'b0;
        pix.valid      = 1'b0;
        pix.req_type   = REQ_PIXEL;
        pix.src_pixel  = '0;
        pix.dst_pixel  = '0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_BLEND_MODE;
        cfg.data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        sent_count     = 0;
        m_mode = MODE_COPY; m_fill = '0; m_dx = '0; m_dy = '0; m_w = '0; m_h = '0;
        col_pos = 0; row_pos = 0;
        box_none = 1'b1;
        box_l = 0; box_t = 0; box_r = 0; box_b = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the image is empty: done without a write; flush of empty box.
        push_pix(32'hFFFF_FFFF, 32'h0000_0000);
        push_flush();

        // Plain copy at the origin, field extremes.
        set_image(MODE_COPY, 24'h000000, 0, 0, 2, 2);
        push_pix(32'h0000_0000, 32'hFFFF_FFFF);
        push_pix(32'hFFFF_FFFF, 32'h0000_0000);
        push_pix(32'h5A5A_A5A5, 32'hA5A5_5A5A);
        push_pix(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_flush();

        // Per-pixel alpha in the bottom-right corner; the right column clips.
        // A write to a missing register mid-image must not restart the walk.
        set_image(MODE_ALPHA, 24'h000000, SCREEN_W - 2, SCREEN_H - 2, 3, 2);
        push_pix(32'h00FF_FFFF, 32'h1234_5678);      // clear
        push_pix(32'hFF12_3456, 32'hAB00_0000);      // opaque
        push_pix(32'h80FF_FFFF, 32'h7700_0000);      // clipped
        cfg_write(CFG_IDX_SPARE, 24'($urandom));
        push_pix(32'h80FF_FFFF, 32'h0000_0000);      // half, src above dst
        push_pix(32'h8000_0000, 32'hC0FF_FFFF);      // half, src below dst
        push_pix(32'h01FF_00FF, 32'h0000_FF00);      // clipped
        cfg_write(CFG_IDX_TOP, 24'($urandom));
        push_pix(32'hFE00_FF00, 32'h00FF_00FF);      // restarts at col 0, row 0
        push_flush();

        // Coverage with a white fill, image hanging off the top-left.
        set_image(MODE_COVER, 24'hFFFFFF, -1, -1, 2, 2);
        push_pix(32'hFFFF_FF00, 32'h0000_0000);
        push_pix(32'h0000_00FF, 32'h0000_0000);
        push_pix(32'h0000_0007, 32'h8010_2030);
        push_pix(32'h0000_00C8, 32'hFF40_8000);      // only this one lands
        push_flush();

        // Unused mode code, oversized and extreme placements.
        set_image(MODE_SPARE, 24'h123456, -2048, 2047, 12'hFFF, 1);
        push_pix($urandom, $urandom);
        push_pix($urandom, $urandom);
        set_image(MODE_SPARE, 24'hFFFFFF, SCREEN_W - 4, 0, 12'hFFF, 12'hFFF);
        push_pix(32'hDEAD_BEEF, $urandom);
        push_pix(32'h0000_0001, $urandom);
        push_pix(32'h8000_0000, $urandom);
        push_flush();
        set_image(MODE_COVER, 24'h000000, 2047, -2048, 12'd2048, 12'd2048);
        push_pix(rand_src(), $urandom);

        // Random images over the idling phases: none, sender, receiver, both.
        for (ph = 0; ph < 4; ph++) begin
            wait_quiet();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            goal = sent_count + 112;
            while (sent_count < goal) random_image();
        end

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/cab_pkg.sv
src/cab_if.sv
src/clipped_alpha_blit_unit.sv
sim/tb.sv
